// ----- rtl/core/rrlt_pkg.sv -----
// Package with the shared constants, types and helper function of the rate receiver.
`default_nettype none
package rrlt_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int LOSS_RECORDS = 8;
    localparam int REC_CW = $clog2(LOSS_RECORDS + 1);
    localparam int MAX_GAP = 32;
    localparam int GAP_W = $clog2(MAX_GAP + 1);
    localparam int FRAC_W = 24;
    localparam int W_W = $clog2(LOSS_RECORDS + 3);
    localparam int NUM_W = $clog2(LOSS_RECORDS * (LOSS_RECORDS + 2) + 1);
    localparam int DEN_W = $clog2((LOSS_RECORDS + 1) * HISTORY_DEPTH * (LOSS_RECORDS + 2) + 1);
    localparam int DIVD_W = NUM_W + FRAC_W + 1;
    localparam int RATE_W = 7;
    localparam int LR_W = 25;
    localparam logic [LR_W-1:0] LOSS_ONE = LR_W'(1) << FRAC_W;
    localparam logic [7:0] THRESHOLD_RESET = 8'd5;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] stamp;
    } hist_entry_t;

    typedef struct packed {
        logic              make;
        logic              kill;
        logic [CNT_W-1:0]  length;
        logic [31:0]       base;
        logic [MAX_GAP-1:0] map;
        logic [31:0]       seq;
    } loss_cmd_t;

    typedef struct packed {
        logic             empty;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } loss_sum_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_SHIFT_TAIL,
        ST_WRITE_NEW,
        ST_RECOMP,
        ST_LOSS,
        ST_DIV,
        ST_DONE
    } rrlt_state_t;

    function automatic logic [W_W-1:0] weight(input int i);
        if (i < LOSS_RECORDS / 2) begin
            return W_W'(LOSS_RECORDS + 2);
        end
        return W_W'(2 * (LOSS_RECORDS - i));
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rrlt_if.sv -----
// Stream interfaces for packet beats in and ack beats out.
`default_nettype none
interface rrlt_pkt_if;
    logic               valid;
    logic               ready;
    logic [31:0]        seq_number;
    logic signed [31:0] rtt_ms;
    logic [31:0]        send_time_ms;
    modport source (output valid, output seq_number, output rtt_ms, output send_time_ms,
                    input ready);
    modport sink (input valid, input seq_number, input rtt_ms, input send_time_ms,
                  output ready);
endinterface

interface rrlt_ack_if;
    logic        valid;
    logic        ready;
    logic        tracked;
    logic [31:0] ack_seq;
    logic [6:0]  receive_rate;
    logic [24:0] loss_rate;
    logic [31:0] echo_time_ms;
    modport source (output valid, output tracked, output ack_seq, output receive_rate,
                    output loss_rate, output echo_time_ms, input ready);
    modport sink (input valid, input tracked, input ack_seq, input receive_rate,
                  input loss_rate, input echo_time_ms, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rrlt_hist_mem.sv -----
// History memory of sequence and send time pairs, one write and one registered read port.
`default_nettype none
module rrlt_hist_mem
    import rrlt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [HIST_AW-1:0] waddr,
    input  wire hist_entry_t        wdata,
    input  wire logic [HIST_AW-1:0] raddr,
    output hist_entry_t             rdata
);

    hist_entry_t mem [HISTORY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/rrlt_loss_recs.sv -----
// Loss records with their create and hole-fill updates and the weighted sums.
`default_nettype none
module rrlt_loss_recs
    import rrlt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire loss_cmd_t        cmd,
    input  wire logic [CNT_W-1:0] hist_count,
    output loss_sum_t             sum
);

    logic [CNT_W-1:0]   len_reg  [LOSS_RECORDS];
    logic [31:0]        base_reg [LOSS_RECORDS];
    logic [MAX_GAP-1:0] map_reg  [LOSS_RECORDS];
    logic [REC_CW-1:0]  rc_reg;

    logic               drop_any;
    logic [REC_CW-1:0]  drop_idx;
    logic [MAX_GAP-1:0] new_map  [LOSS_RECORDS];

    // The hole is cleared in every record that holds it, up to the first record it empties.
    always_comb
    begin
        logic [31:0] off;
        drop_any = 1'b0;
        drop_idx = '0;
        for (int i = 0; i < LOSS_RECORDS; i++)
        begin
            off = cmd.seq - base_reg[i];
            new_map[i] = map_reg[i];
            if (!drop_any && (REC_CW'(i) < rc_reg) && (off < 32'(MAX_GAP)) &&
                map_reg[i][off[GAP_W-2:0]])
            begin
                new_map[i] = map_reg[i] & ~(MAX_GAP'(1) << off[GAP_W-2:0]);
                if (new_map[i] == '0)
                begin
                    drop_any = 1'b1;
                    drop_idx = REC_CW'(i);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= '0;
        end
        else if (cmd.make)
        begin
            if (rc_reg < REC_CW'(LOSS_RECORDS))
            begin
                rc_reg <= rc_reg + REC_CW'(1);
            end
        end
        else if (cmd.kill && drop_any)
        begin
            rc_reg <= rc_reg - REC_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.make)
        begin
            for (int j = LOSS_RECORDS - 1; j > 0; j--)
            begin
                len_reg[j]  <= len_reg[j-1];
                base_reg[j] <= base_reg[j-1];
                map_reg[j]  <= map_reg[j-1];
            end
            len_reg[0]  <= cmd.length;
            base_reg[0] <= cmd.base;
            map_reg[0]  <= cmd.map;
        end
        else if (cmd.kill)
        begin
            for (int j = 0; j < LOSS_RECORDS; j++)
            begin
                if (!drop_any || (REC_CW'(j) < drop_idx))
                begin
                    map_reg[j] <= new_map[j];
                end
            end
            for (int j = 0; j < LOSS_RECORDS - 1; j++)
            begin
                if (drop_any && (REC_CW'(j) >= drop_idx))
                begin
                    len_reg[j]  <= len_reg[j+1];
                    base_reg[j] <= base_reg[j+1];
                    map_reg[j]  <= map_reg[j+1];
                end
            end
        end
    end

    always_comb
    begin
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        num = NUM_W'(weight(0));
        den = DEN_W'(hist_count) * DEN_W'(weight(0));
        for (int i = 0; i < LOSS_RECORDS - 1; i++)
        begin
            if (REC_CW'(i) < rc_reg)
            begin
                den = den + DEN_W'(len_reg[i]) * DEN_W'(weight(i));
                num = num + NUM_W'(weight(i + 1));
            end
        end
        sum.empty = (rc_reg == '0);
        sum.num   = num;
        sum.den   = den;
    end

endmodule
`default_nettype wire

// ----- rtl/core/rrlt_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module rrlt_divider
    import rrlt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DEN_W-1:0]  divisor,
    output logic                   done,
    output logic [DIVD_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(DIVD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  dsr_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, dsr_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- rtl/core/rate_receiver_loss_tracker.sv -----
// Top level of the rate receiver: history walk sequencer, loss records and ack output.
//
//   channel | dir | handshake          | payload
//   pkt     | in  | valid/ready        | seq_number, rtt_ms, send_time_ms
//   ack     | out | valid/ready        | tracked, ack_seq, receive_rate, loss_rate, echo_time_ms
//   cfg     | in  | cfg_we, no wait    | cfg_data (reorder_threshold)
//
// An untracked beat goes straight from idle to the done state. A tracked beat takes one pass
// over the history and, where needed, a shift of the history memory for an insertion and a
// pass to rebuild the first missing number, then the loss-rate divider when loss records are
// held; the history walks go one entry at a time through the single read port of the memory.
// Reset clears the counts, so no clearing pass is needed. A finished ack waits in the output
// register while the next beat is accepted; the block stalls only when that register is full.
`default_nettype none
module rate_receiver_loss_tracker
    import rrlt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rrlt_pkt_if.sink    pkt,
    rrlt_ack_if.source  ack,
    input  wire logic   cfg_we,
    input  wire logic [7:0] cfg_data
);

    rrlt_state_t state_reg, state_next;

    logic [7:0]         thr_reg;
    logic [31:0]        s_reg, t_reg, rtt_reg;
    logic [CNT_W-1:0]   cnt_reg, k_reg, idx_reg;
    logic               dv_reg, brk_reg, stop_reg;
    logic [31:0]        fm_reg, seq0_reg, seql_reg, prev_reg, bseq_reg;
    logic               bfound_reg, bnz_reg, pfound_reg, recomp_reg, pend_reg, trk_reg;
    logic [MAX_GAP-1:0] gmap_reg;
    logic [HIST_AW-1:0] pos_reg, pend_addr_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [LR_W-1:0]    lr_reg;

    logic               outv_reg, out_trk_reg;
    logic [31:0]        out_seq_reg, out_echo_reg;
    logic [RATE_W-1:0]  out_rate_reg;
    logic [LR_W-1:0]    out_lr_reg;

    logic               mem_we;
    logic [HIST_AW-1:0] mem_waddr, mem_raddr;
    hist_entry_t        mem_wdata, mem_rdata;
    loss_cmd_t          loss_cmd;
    loss_sum_t          loss_sum;
    logic               div_start, div_done;
    logic [DIVD_W-1:0]  div_quo;

    logic               accept, untracked, issue, issue_rc, out_free;
    logic               br_loss, br_head, br_below;
    logic [CNT_W-1:0]   nfull;
    logic [31:0]        fm_diff;
    logic signed [33:0] d34, r34;

    assign accept    = pkt.valid && pkt.ready;
    assign untracked = (pkt.seq_number == '0) || pkt.rtt_ms[31];
    assign issue     = (k_reg < cnt_reg);
    assign issue_rc  = (k_reg < cnt_reg) && !stop_reg;
    assign out_free  = !outv_reg || ack.ready;
    assign fm_diff   = s_reg - fm_reg;
    assign br_loss   = (fm_reg != '0) && ($signed(fm_diff) >= $signed({24'd0, thr_reg}));
    assign br_head   = (seq0_reg < s_reg);
    assign br_below  = (s_reg < seql_reg);
    assign nfull     = (cnt_reg >= CNT_W'(HISTORY_DEPTH)) ? CNT_W'(HISTORY_DEPTH - 1) : cnt_reg;
    assign d34       = 34'($signed(t_reg - mem_rdata.stamp));
    assign r34       = $signed({2'b00, rtt_reg});

    rrlt_hist_mem u_hist_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rrlt_loss_recs u_loss_recs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (loss_cmd),
        .hist_count (cnt_reg),
        .sum        (loss_sum)
    );

    rrlt_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DIVD_W'({loss_sum.num, FRAC_W'(0)}) + DIVD_W'(loss_sum.den >> 1)),
        .divisor  (loss_sum.den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = untracked ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !dv_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (br_loss || (cnt_reg == '0))
                begin
                    state_next = ST_WRITE_NEW;
                end
                else if (br_head)
                begin
                    state_next = (nfull != '0) ? ST_SHIFT : ST_WRITE_NEW;
                end
                else if (br_below)
                begin
                    state_next = ST_LOSS;
                end
                else if (pfound_reg)
                begin
                    state_next = (nfull > CNT_W'(pos_reg)) ? ST_SHIFT : ST_WRITE_NEW;
                end
                else
                begin
                    state_next = (fm_reg == s_reg) ? ST_RECOMP : ST_LOSS;
                end
            end
            ST_SHIFT:
            begin
                if (k_reg == CNT_W'(pos_reg))
                begin
                    state_next = ST_SHIFT_TAIL;
                end
            end
            ST_SHIFT_TAIL:
            begin
                state_next = ST_WRITE_NEW;
            end
            ST_WRITE_NEW:
            begin
                state_next = recomp_reg ? ST_RECOMP : ST_LOSS;
            end
            ST_RECOMP:
            begin
                if (!issue_rc && !dv_reg)
                begin
                    state_next = ST_LOSS;
                end
            end
            ST_LOSS:
            begin
                state_next = (loss_sum.empty || (loss_sum.den == '0)) ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = k_reg[HIST_AW-1:0];
        loss_cmd  = '0;
        div_start = 1'b0;
        loss_cmd.seq = s_reg;
        case (state_reg)
            ST_DECIDE:
            begin
                if (br_loss)
                begin
                    loss_cmd.make   = 1'b1;
                    loss_cmd.length = cnt_reg;
                    loss_cmd.base   = bfound_reg ? bseq_reg + 32'd1 : 32'd0;
                    loss_cmd.map    = (bfound_reg && bnz_reg) ? gmap_reg : '0;
                end
                else if ((cnt_reg != '0) && !br_head && br_below)
                begin
                    loss_cmd.kill = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                mem_we    = pend_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = mem_rdata;
            end
            ST_SHIFT_TAIL:
            begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr_reg;
                mem_wdata = mem_rdata;
            end
            ST_WRITE_NEW:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = '{seq: s_reg, stamp: t_reg};
            end
            ST_LOSS:
            begin
                div_start = !loss_sum.empty && (loss_sum.den != '0);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg   <= THRESHOLD_RESET;
            cnt_reg   <= '0;
            fm_reg    <= '0;
            outv_reg  <= 1'b0;
            dv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                outv_reg <= 1'b1;
            end
            else if (ack.valid && ack.ready)
            begin
                outv_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    dv_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    dv_reg <= issue;
                end
                ST_DECIDE:
                begin
                    pend_reg <= 1'b0;
                    if (br_loss)
                    begin
                        fm_reg  <= '0;
                        cnt_reg <= CNT_W'(1);
                    end
                    else if (cnt_reg == '0)
                    begin
                        cnt_reg <= CNT_W'(1);
                    end
                    else if (br_head)
                    begin
                        cnt_reg <= nfull + CNT_W'(1);
                        if ((fm_reg == '0) && (seq0_reg + 32'd1 != s_reg))
                        begin
                            fm_reg <= seq0_reg + 32'd1;
                        end
                    end
                    else if (!br_below)
                    begin
                        if (pfound_reg)
                        begin
                            cnt_reg <= nfull + CNT_W'(1);
                        end
                        if (fm_reg == s_reg)
                        begin
                            fm_reg <= '0;
                        end
                    end
                end
                ST_SHIFT:
                begin
                    pend_reg <= 1'b1;
                end
                ST_RECOMP:
                begin
                    dv_reg <= issue_rc;
                    if (dv_reg && !stop_reg && (idx_reg != '0) && (mem_rdata.seq != s_reg) &&
                        (prev_reg != mem_rdata.seq + 32'd1))
                    begin
                        fm_reg <= mem_rdata.seq + 32'd1;
                    end
                end
                default:
                begin
                    dv_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                s_reg      <= pkt.seq_number;
                t_reg      <= pkt.send_time_ms;
                rtt_reg    <= pkt.rtt_ms;
                trk_reg    <= !untracked;
                k_reg      <= '0;
                rate_reg   <= RATE_W'(1);
                brk_reg    <= 1'b0;
                bfound_reg <= 1'b0;
                pfound_reg <= 1'b0;
                lr_reg     <= '0;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    k_reg <= k_reg + CNT_W'(1);
                end
                idx_reg <= k_reg;
                if (dv_reg)
                begin
                    if (!d34[33] && !brk_reg)
                    begin
                        if (d34 < r34)
                        begin
                            rate_reg <= rate_reg + RATE_W'(1);
                        end
                        else if (d34 > (r34 <<< 1))
                        begin
                            brk_reg <= 1'b1;
                        end
                    end
                    if (idx_reg == '0)
                    begin
                        seq0_reg <= mem_rdata.seq;
                    end
                    if (idx_reg == cnt_reg - CNT_W'(1))
                    begin
                        seql_reg <= mem_rdata.seq;
                    end
                    if (!bfound_reg && (mem_rdata.seq + 32'd1 == fm_reg))
                    begin
                        logic [31:0] gap;
                        gap = prev_reg - mem_rdata.seq - 32'd1;
                        bfound_reg <= 1'b1;
                        bnz_reg    <= (idx_reg != '0);
                        bseq_reg   <= mem_rdata.seq;
                        gmap_reg   <= (gap >= 32'(MAX_GAP)) ? '1 :
                                      ~('1 << gap[GAP_W-2:0]);
                    end
                    if (!pfound_reg && (idx_reg != '0) && (mem_rdata.seq < s_reg))
                    begin
                        pfound_reg <= 1'b1;
                        pos_reg    <= idx_reg[HIST_AW-1:0];
                    end
                    prev_reg <= mem_rdata.seq;
                end
            end
            ST_DECIDE:
            begin
                stop_reg <= 1'b0;
                if (br_loss || (cnt_reg == '0) || br_head)
                begin
                    recomp_reg <= 1'b0;
                    k_reg      <= nfull - CNT_W'(1);
                    pos_reg    <= '0;
                end
                else if (!br_below)
                begin
                    recomp_reg <= (fm_reg == s_reg);
                    k_reg      <= pfound_reg ? nfull - CNT_W'(1) : '0;
                end
                else
                begin
                    recomp_reg <= 1'b0;
                    k_reg      <= nfull - CNT_W'(1);
                end
            end
            ST_SHIFT:
            begin
                pend_addr_reg <= HIST_AW'(k_reg + CNT_W'(1));
                k_reg         <= k_reg - CNT_W'(1);
            end
            ST_WRITE_NEW:
            begin
                k_reg <= '0;
            end
            ST_RECOMP:
            begin
                if (issue_rc)
                begin
                    k_reg <= k_reg + CNT_W'(1);
                end
                idx_reg <= k_reg;
                if (dv_reg && !stop_reg)
                begin
                    if ((idx_reg != '0) && (mem_rdata.seq == s_reg))
                    begin
                        stop_reg <= 1'b1;
                    end
                    prev_reg <= mem_rdata.seq;
                end
            end
            ST_LOSS:
            begin
                if (loss_sum.empty)
                begin
                    lr_reg <= '0;
                end
                else if (loss_sum.den == '0)
                begin
                    lr_reg <= LOSS_ONE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    lr_reg <= (div_quo > DIVD_W'(LOSS_ONE)) ? LOSS_ONE : LR_W'(div_quo);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_trk_reg  <= trk_reg;
                    out_seq_reg  <= trk_reg ? s_reg : '0;
                    out_echo_reg <= trk_reg ? t_reg : '0;
                    out_rate_reg <= trk_reg ? rate_reg : '0;
                    out_lr_reg   <= trk_reg ? lr_reg : '0;
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign pkt.ready        = (state_reg == ST_IDLE);
    assign ack.valid        = outv_reg;
    assign ack.tracked      = out_trk_reg;
    assign ack.ack_seq      = out_seq_reg;
    assign ack.receive_rate = out_rate_reg;
    assign ack.loss_rate    = out_lr_reg;
    assign ack.echo_time_ms = out_echo_reg;

endmodule
`default_nettype wire

// ----- rtl/core/rrlt_checker.sv -----
// Port-level assertions for the rate receiver and the bind that attaches them.
`default_nettype none
module rrlt_checker
    import rrlt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        ack_valid,
    input wire logic        ack_ready,
    input wire logic        ack_tracked,
    input wire logic [31:0] ack_seq,
    input wire logic [6:0]  receive_rate,
    input wire logic [24:0] loss_rate,
    input wire logic [31:0] echo_time_ms
);

    // A stalled ack beat stays offered.
    a_ack_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ack_valid && !ack_ready |=> ack_valid)
        else $error("ack beat dropped while stalled");

    // An untracked packet gives an all-zero ack.
    a_untracked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ack_valid && !ack_tracked |-> (ack_seq == '0) && (receive_rate == '0) &&
        (loss_rate == '0) && (echo_time_ms == '0))
        else $error("untracked ack carries data");

    // A tracked ack counts at least the packet itself and a bounded loss rate.
    a_tracked_range: assert property (@(posedge clk) disable iff (!rst_n)
        ack_valid && ack_tracked |-> (receive_rate != '0) && (loss_rate <= LOSS_ONE))
        else $error("tracked ack fields out of range");

    // Sequence number zero is never tracked.
    a_tracked_seq: assert property (@(posedge clk) disable iff (!rst_n)
        ack_valid && ack_tracked |-> (ack_seq != '0))
        else $error("tracked ack with sequence zero");

endmodule

bind rate_receiver_loss_tracker rrlt_checker u_rrlt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .ack_valid    (ack.valid),
    .ack_ready    (ack.ready),
    .ack_tracked  (ack.tracked),
    .ack_seq      (ack.ack_seq),
    .receive_rate (ack.receive_rate),
    .loss_rate    (ack.loss_rate),
    .echo_time_ms (ack.echo_time_ms)
);
`default_nettype wire
